// ===== rtl/pgs_pkg.sv =====
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types and constants for the gain-scheduled PID controller.
// ----------------------------------------------------------------------------
`default_nettype none
package pgs_pkg;
	localparam int unsigned NUM_REGS = 8;
	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_GAIN_P = 3'd1;
	localparam logic [2:0] REG_GAIN_I = 3'd2;
	localparam logic [2:0] REG_GAIN_D = 3'd3;
	localparam logic [2:0] REG_DRIVE_LIM = 3'd4;
	localparam logic [2:0] REG_SLEW_LIM = 3'd5;
	localparam logic [2:0] REG_SCHED_THR = 3'd6;
	localparam logic [2:0] REG_SCHED_SCL = 3'd7;

	localparam logic OP_STEP = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_INT_MUL,
		ST_INT_ACC,
		ST_DIV,
		ST_KP_MUL,
		ST_KP_SEL,
		ST_P_MUL,
		ST_I_MUL,
		ST_D_MUL,
		ST_LIMIT,
		ST_OUT
	} state_t;

	// divider control / status
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/pid_gain_sched_rate_limited.sv =====
// ----------------------------------------------------------------------------
// pid_gain_sched_rate_limited
// PID controller with gain scheduling, integral clamp and slew limiting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries op, measured_angle, step_time.
//   Output channel (out_valid/out_stall) carries drive_out, clamped, slewed.
//   One result per input transaction, in order.
//   A control step runs through one shared 33x33 multiplier (five products)
//   and a radix-2 divider for the derivative (49 quotient bits at the
//   default FRAC_BITS), one transaction at a time; the next input can be
//   accepted as early as the cycle in which the result appears.
//   A clear goes straight from idle to the result stage, skipping the step.
//   The result register holds while out_stall is high; the next input is
//   accepted once the result register is free or being taken.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are taken any cycle
//   but must only happen while the block is idle.
//   Reset clears the integral, previous error and previous drive, restores
//   register defaults and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pid_gain_sched_rate_limited #(
	parameter int FRAC_BITS = 16,
	parameter int INTEGRAL_BOUND = 327680
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [2:0]        cfg_index,
	input  wire  [31:0]       cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire               op,
	input  wire signed [31:0] measured_angle,
	input  wire  [20:0]       step_time,
	output logic              out_valid,
	input  wire               out_stall,
	output logic signed [31:0] drive_out,
	output logic              clamped,
	output logic              slewed
);
	import pgs_pkg::*;

	localparam int NUM_W = 33 + FRAC_BITS;

	state_t state_q, state_d;

	logic signed [31:0] target_q, gp_q, gi_q, gd_q;
	logic [30:0] dlim_q, slim_q, thr_q, scl_q;
	logic signed [31:0] integ_q, perr_q, pdrv_q;

	logic signed [31:0] meas_q, err_q, deriv_q, kp_q, accum_p_q, accum_i_q, term_q;
	logic [20:0] dt_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [65:0] prod_sh;

	div_ctl_t dctl;
	div_sts_t dsts;
	logic signed [NUM_W-1:0] dnum;
	logic signed [NUM_W:0]   dquot;

	logic signed [31:0] res_q;
	logic clamped_q, slewed_q, ovalid_q;

	logic accept, deliver;

	assign accept = in_valid && !in_stall;
	assign deliver = ovalid_q && !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (ovalid_q && out_stall);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 32'sd0;
			gp_q <= 32'sd108134;
			gi_q <= 32'sd0;
			gd_q <= 32'sd29491;
			dlim_q <= 31'd983040;
			slim_q <= 31'd65536;
			thr_q <= 31'h7fffffff;
			scl_q <= 31'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET: target_q <= cfg_data;
				REG_GAIN_P: gp_q <= cfg_data;
				REG_GAIN_I: gi_q <= cfg_data;
				REG_GAIN_D: gd_q <= cfg_data;
				REG_DRIVE_LIM: dlim_q <= cfg_data[30:0];
				REG_SLEW_LIM: slim_q <= cfg_data[30:0];
				REG_SCHED_THR: thr_q <= cfg_data[30:0];
				REG_SCHED_SCL: scl_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		ma = 33'sd0;
		mb = 33'sd0;
		case (state_q)
			ST_INT_MUL: begin ma = 33'(err_q); mb = $signed({12'd0, dt_q}); end
			ST_KP_MUL: begin ma = 33'(gp_q); mb = $signed({2'b00, scl_q}); end
			ST_P_MUL: begin ma = 33'(kp_q); mb = 33'(err_q); end
			ST_I_MUL: begin ma = 33'(gi_q); mb = 33'(integ_q); end
			ST_D_MUL: begin ma = 33'(gd_q); mb = 33'(deriv_q); end
			default: ;
		endcase
	end

	assign prod_sh = prod_q >>> FRAC_BITS;

	// derivative divider
	logic signed [32:0] ediff;
	assign ediff = 33'(err_q) - 33'(perr_q);
	assign dnum = NUM_W'(ediff) <<< FRAC_BITS;
	assign dctl.start = (state_q == ST_INT_ACC);

	pgs_div #(.NUM_W(NUM_W), .DEN_W(21)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(dnum), .den(dt_q),
		.sts(dsts), .quot(dquot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = (op == OP_CLEAR) ? ST_OUT : ST_ERR;
			ST_ERR: state_d = ST_INT_MUL;
			ST_INT_MUL: state_d = ST_INT_ACC;
			ST_INT_ACC: state_d = ST_DIV;
			ST_DIV: if (dsts.done) state_d = ST_KP_MUL;
			ST_KP_MUL: state_d = ST_KP_SEL;
			ST_KP_SEL: state_d = ST_P_MUL;
			ST_P_MUL: state_d = ST_I_MUL;
			ST_I_MUL: state_d = ST_D_MUL;
			ST_D_MUL: state_d = ST_LIMIT;
			ST_LIMIT: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	logic signed [33:0] ediff_m;
	logic [32:0] abs_err;
	logic signed [33:0] iacc;
	logic signed [33:0] ssum;
	logic signed [32:0] lim, hi, lo;
	logic signed [32:0] cres;
	logic clear_q;
	logic signed [65:0] prod_d;

	assign ediff_m = 34'(target_q) - 34'(meas_q);
	assign abs_err = err_q[31] ? 33'(-34'(err_q)) : 33'(err_q);
	assign prod_d = ma * mb;

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (accept) begin
			meas_q <= measured_angle;
			dt_q <= (step_time == 21'd0) ? 21'd1 : step_time;
		end
		case (state_q)
			ST_ERR: err_q <= sat32(66'(ediff_m));
			ST_DIV: if (dsts.done) deriv_q <= sat32(66'(dquot));
			ST_KP_SEL: kp_q <= (abs_err > {2'b00, thr_q}) ? sat32(prod_sh) : gp_q;
			ST_I_MUL: accum_p_q <= sat32(prod_sh);
			ST_D_MUL: accum_i_q <= sat32(prod_sh);
			ST_LIMIT: term_q <= sat32(prod_sh);
			default: ;
		endcase
	end

	// state registers
	assign iacc = 34'(integ_q) + 34'(sat32(prod_sh));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			perr_q <= '0;
			pdrv_q <= '0;
			clear_q <= 1'b0;
		end else begin
			if (accept) clear_q <= (op == OP_CLEAR);
			if (state_q == ST_INT_ACC) begin
				if (iacc > 34'(INTEGRAL_BOUND)) integ_q <= 32'(INTEGRAL_BOUND);
				else if (iacc < -34'(INTEGRAL_BOUND)) integ_q <= -32'(INTEGRAL_BOUND);
				else integ_q <= iacc[31:0];
			end
			if (state_q == ST_DIV && dsts.done) perr_q <= err_q;
			if (state_q == ST_OUT) begin
				pdrv_q <= clear_q ? 32'sd0 : cres[31:0];
				if (clear_q) begin
					integ_q <= '0;
					perr_q <= '0;
				end
			end
		end
	end

	// final sum, clamp and slew (ST_OUT)
	logic c_fl, s_fl;
	always_comb begin
		ssum = 34'(accum_p_q) + 34'(accum_i_q) + 34'(term_q);
		cres = 33'(sat32(66'(ssum)));
		lim = $signed({2'b00, dlim_q});
		c_fl = 1'b0;
		s_fl = 1'b0;
		if (cres > lim) begin cres = lim; c_fl = 1'b1; end
		if (cres < -lim) begin cres = -lim; c_fl = 1'b1; end
		hi = 33'(pdrv_q) + $signed({2'b00, slim_q});
		lo = 33'(pdrv_q) - $signed({2'b00, slim_q});
		if (cres > hi) begin cres = hi; s_fl = 1'b1; end
		if (cres < lo) begin cres = lo; s_fl = 1'b1; end
		cres = 33'(sat32(66'(cres)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_OUT) begin
			ovalid_q <= 1'b1;
		end else if (deliver) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			res_q <= clear_q ? 32'sd0 : cres[31:0];
			clamped_q <= clear_q ? 1'b0 : c_fl;
			slewed_q <= clear_q ? 1'b0 : s_fl;
		end
	end

	assign out_valid = ovalid_q;
	assign drive_out = res_q;
	assign clamped = clamped_q;
	assign slewed = slewed_q;

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> !ovalid_q)
		else $error("result stage entered while result register full");
	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= 32'(INTEGRAL_BOUND)) && (integ_q >= -32'(INTEGRAL_BOUND)))
		else $error("integral out of bound");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dsts.busy |-> (state_q == ST_DIV)) else $error("divider busy out of phase");
`endif
endmodule
`default_nettype wire

// ===== rtl/pgs_div.sv =====
// ----------------------------------------------------------------------------
// pgs_div
// Radix-2 restoring divider: signed dividend by unsigned divisor, result
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pgs_div #(
	parameter int NUM_W = 49,
	parameter int DEN_W = 21
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  pgs_pkg::div_ctl_t        ctl,
	input  wire signed [NUM_W-1:0]   num,
	input  wire        [DEN_W-1:0]   den,
	output pgs_pkg::div_sts_t        sts,
	output logic signed [NUM_W:0]    quot
);
	import pgs_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [NUM_W-1:0] mag;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign trial = {rem_q[DEN_W-1:0], q_q[NUM_W-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			q_q <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W:0];
				q_q <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

`ifndef SYNTHESIS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without busy");
	a_busy_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("busy and done together");
`endif
endmodule
`default_nettype wire
